FILE: sv/cdf_pkg.sv
// Shared types and constants for the camera deadzone follower.
`default_nettype none
package cdf_pkg;

	localparam int SQRT_BITS_DEF = 64;
	localparam int CNT_W = 6;
	localparam int MS_W = 24;
	localparam int MAG_W = 33;
	localparam int MUL_W = 33;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [2:0] REG_DZ_X = 3'd0;
	localparam logic [2:0] REG_DZ_Y = 3'd1;
	localparam logic [2:0] REG_STIFF = 3'd2;
	localparam logic [2:0] REG_MAX_SPEED = 3'd3;
	localparam logic [2:0] REG_WMIN_X = 3'd4;
	localparam logic [2:0] REG_WMAX_X = 3'd5;
	localparam logic [2:0] REG_WMIN_Y = 3'd6;
	localparam logic [2:0] REG_WMAX_Y = 3'd7;

	localparam logic [16:0] STIFF_ONE = 17'd65536;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MX,
		ST_MY,
		ST_MS,
		ST_SQX,
		ST_SQY,
		ST_SQM,
		ST_CMP,
		ST_SHIFT,
		ST_RSQ1,
		ST_RSQ2,
		ST_RSQ3,
		ST_SQRT,
		ST_LEN,
		ST_DVX0,
		ST_DIVX,
		ST_DVY0,
		ST_DIVY,
		ST_ADD,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: sv/camera_deadzone_follow.sv
// Camera deadzone follower: sequencer around one shared multiplier, root and divide steps.
//
// Input channel (in_valid / in_stall): one request per item, opcode 0 is a follow
// tick using time_step and the target point, opcode 1 loads the camera position.
// Output channel (out_valid / out_stall): one result per request, held in an
// output register until taken. Configuration channel (cfg_valid / cfg_ready):
// cfg_ready is always high; write only while no request is in flight.
// A limited tick adds a normalising shift of one bit a cycle, an integer root and
// two restoring divides.
// One request is processed at a time; in_stall is high from acceptance until
// the result is moved into the output register. A stalled receiver holds the
// result and, once the next request is done, the block waits for the register
// to drain. Reset clears the camera to the origin, the registers to their
// defaults and drops any pending result.
`default_nettype none
module camera_deadzone_follow #(
	parameter int SQRT_BITS = cdf_pkg::SQRT_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               opcode,
	input  wire logic [15:0]        time_step,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      cam_x,
	output logic signed [31:0]      cam_y,
	output logic                    speed_limited,
	output logic                    clamped_x,
	output logic                    clamped_y,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int H = SQRT_BITS / 2;
	localparam int RW = 2 * H;
	localparam int DW = H + cdf_pkg::MS_W;
	localparam int MAG_W = cdf_pkg::MAG_W;
	localparam int MS_W = cdf_pkg::MS_W;
	localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (H - 1);
	localparam logic [MAG_W-1:0] BIG_LIM = MAG_W'(1) << MS_W;

	cdf_pkg::state_t state_q, state_d;

	logic [30:0] dz_x_q, dz_y_q;
	logic [16:0] stiff_q;
	logic [23:0] max_speed_q;
	logic signed [31:0] wmin_x_q, wmax_x_q, wmin_y_q, wmax_y_q;
	logic signed [31:0] camx_q, camy_q;

	logic [15:0] dt_q;
	logic signed [31:0] px_q, py_q;
	logic [MAG_W-1:0] ax_q, ay_q, big_q;
	logic negx_q, negy_q;
	logic [MS_W-1:0] ms_q;
	logic [49:0] sum_q;
	logic lim_q, hx_q, hy_q;
	logic [2*cdf_pkg::MUL_W-1:0] mul_q;
	logic [cdf_pkg::MUL_W-1:0] mul_a, mul_b;
	logic [RW-1:0] rad_q, res_q, bit_q;
	logic [H-1:0] len_q;
	logic [H:0] rem_q;
	logic [MS_W-1:0] quo_q;
	logic [cdf_pkg::CNT_W-1:0] cnt_q;
	logic out_free;

	// combinational helpers
	logic signed [32:0] dx, dy;
	logic [MAG_W-1:0] mx, my, ex, ey;
	logic [16:0] stiff_eff;
	logic [48:0] step_rnd;
	logic [39:0] ms_rnd;
	logic [RW-1:0] sq_try;
	logic [DW-1:0] dividend;
	logic [H+1:0] trial;
	logic trial_ge;
	logic signed [33:0] nx, ny;
	logic signed [31:0] cx_new, cy_new;
	logic hx_new, hy_new;

	function automatic logic signed [31:0] win_clamp(input logic signed [33:0] v,
		input logic signed [31:0] lo, input logic signed [31:0] hi);
		logic signed [33:0] lo_e, hi_e;
		lo_e = 34'(lo);
		hi_e = 34'(hi);
		if (lo <= hi && v < lo_e) return lo;
		if (lo <= hi && v > hi_e) return hi;
		if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -34'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic win_hit(input logic signed [33:0] v,
		input logic signed [31:0] lo, input logic signed [31:0] hi);
		return (lo <= hi) && (v < 34'(lo) || v > 34'(hi));
	endfunction

	// excess offsets are held in ax_q / ay_q between DIFF and the scaling multiplies
	function automatic logic [MAG_W-1:0] ex_q_sel(input logic sel_y);
		return sel_y ? ay_q : ax_q;
	endfunction

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		dx = $signed({px_q[31], px_q}) - $signed({camx_q[31], camx_q});
		dy = $signed({py_q[31], py_q}) - $signed({camy_q[31], camy_q});
		mx = dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
		my = dy[32] ? MAG_W'(-dy) : MAG_W'(dy);
		ex = (mx > {2'b00, dz_x_q}) ? mx - {2'b00, dz_x_q} : '0;
		ey = (my > {2'b00, dz_y_q}) ? my - {2'b00, dz_y_q} : '0;
		stiff_eff = (stiff_q > cdf_pkg::STIFF_ONE) ? cdf_pkg::STIFF_ONE : stiff_q;
		step_rnd = mul_q[48:0] + 49'd32768;
		ms_rnd = mul_q[39:0] + 40'd32768;
		sq_try = res_q + bit_q;
		dividend = mul_q[DW-1:0] + DW'(len_q >> 1);
		trial = {rem_q, quo_q[MS_W-1]};
		trial_ge = trial >= (H+2)'(len_q);
		nx = 34'(camx_q) + (negx_q ? -$signed({1'b0, ax_q}) : $signed({1'b0, ax_q}));
		ny = 34'(camy_q) + (negy_q ? -$signed({1'b0, ay_q}) : $signed({1'b0, ay_q}));
		cx_new = win_clamp(nx, wmin_x_q, wmax_x_q);
		cy_new = win_clamp(ny, wmin_y_q, wmax_y_q);
		hx_new = win_hit(nx, wmin_x_q, wmax_x_q);
		hy_new = win_hit(ny, wmin_y_q, wmax_y_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cdf_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = (opcode == cdf_pkg::OP_LOAD) ? cdf_pkg::ST_DONE : cdf_pkg::ST_DIFF;
			end
			cdf_pkg::ST_DIFF: state_d = cdf_pkg::ST_MX;
			cdf_pkg::ST_MX: state_d = cdf_pkg::ST_MY;
			cdf_pkg::ST_MY: state_d = cdf_pkg::ST_MS;
			cdf_pkg::ST_MS: state_d = (max_speed_q == '0) ? cdf_pkg::ST_ADD : cdf_pkg::ST_SQX;
			cdf_pkg::ST_SQX: state_d = cdf_pkg::ST_SQY;
			cdf_pkg::ST_SQY: state_d = cdf_pkg::ST_SQM;
			cdf_pkg::ST_SQM: state_d = cdf_pkg::ST_CMP;
			cdf_pkg::ST_CMP: begin
				if (big_q >= BIG_LIM || sum_q > mul_q[49:0])
					state_d = cdf_pkg::ST_SHIFT;
				else
					state_d = cdf_pkg::ST_ADD;
			end
			cdf_pkg::ST_SHIFT: if (big_q < LIM) state_d = cdf_pkg::ST_RSQ1;
			cdf_pkg::ST_RSQ1: state_d = cdf_pkg::ST_RSQ2;
			cdf_pkg::ST_RSQ2: state_d = cdf_pkg::ST_RSQ3;
			cdf_pkg::ST_RSQ3: state_d = cdf_pkg::ST_SQRT;
			cdf_pkg::ST_SQRT: if (cnt_q == cdf_pkg::CNT_W'(1)) state_d = cdf_pkg::ST_LEN;
			cdf_pkg::ST_LEN: state_d = cdf_pkg::ST_DVX0;
			cdf_pkg::ST_DVX0: state_d = cdf_pkg::ST_DIVX;
			cdf_pkg::ST_DIVX: if (cnt_q == cdf_pkg::CNT_W'(1)) state_d = cdf_pkg::ST_DVY0;
			cdf_pkg::ST_DVY0: state_d = cdf_pkg::ST_DIVY;
			cdf_pkg::ST_DIVY: if (cnt_q == cdf_pkg::CNT_W'(1)) state_d = cdf_pkg::ST_ADD;
			cdf_pkg::ST_ADD: state_d = cdf_pkg::ST_DONE;
			cdf_pkg::ST_DONE: if (out_free) state_d = cdf_pkg::ST_IDLE;
			default: state_d = cdf_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake and multiplier operand selection
	always_comb begin
		in_stall = (state_q != cdf_pkg::ST_IDLE);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			cdf_pkg::ST_MX: begin
				mul_a = ex_q_sel(1'b0);
				mul_b = {16'd0, stiff_eff};
			end
			cdf_pkg::ST_MY: begin
				mul_a = ex_q_sel(1'b1);
				mul_b = {16'd0, stiff_eff};
			end
			cdf_pkg::ST_MS: begin
				mul_a = {9'd0, max_speed_q};
				mul_b = {17'd0, dt_q};
			end
			cdf_pkg::ST_SQX, cdf_pkg::ST_RSQ1: begin
				mul_a = ax_q;
				mul_b = ax_q;
			end
			cdf_pkg::ST_SQY, cdf_pkg::ST_RSQ2: begin
				mul_a = ay_q;
				mul_b = ay_q;
			end
			cdf_pkg::ST_SQM: begin
				mul_a = {9'd0, ms_q};
				mul_b = {9'd0, ms_q};
			end
			cdf_pkg::ST_LEN: begin
				mul_a = ax_q;
				mul_b = {9'd0, ms_q};
			end
			cdf_pkg::ST_DIVX: begin
				mul_a = ay_q;
				mul_b = {9'd0, ms_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdf_pkg::ST_IDLE;
			out_valid <= 1'b0;
			camx_q <= '0;
			camy_q <= '0;
			dz_x_q <= 31'd40960;
			dz_y_q <= 31'd23040;
			stiff_q <= 17'd11796;
			max_speed_q <= '0;
			wmin_x_q <= 32'sd1;
			wmax_x_q <= '0;
			wmin_y_q <= 32'sd1;
			wmax_y_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					cdf_pkg::REG_DZ_X: dz_x_q <= cfg_data[30:0];
					cdf_pkg::REG_DZ_Y: dz_y_q <= cfg_data[30:0];
					cdf_pkg::REG_STIFF: stiff_q <= cfg_data[16:0];
					cdf_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data[23:0];
					cdf_pkg::REG_WMIN_X: wmin_x_q <= cfg_data;
					cdf_pkg::REG_WMAX_X: wmax_x_q <= cfg_data;
					cdf_pkg::REG_WMIN_Y: wmin_y_q <= cfg_data;
					cdf_pkg::REG_WMAX_Y: wmax_y_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == cdf_pkg::ST_IDLE && in_valid && opcode == cdf_pkg::OP_LOAD) begin
				camx_q <= point_x;
				camy_q <= point_y;
			end
			if (state_q == cdf_pkg::ST_ADD) begin
				camx_q <= cx_new;
				camy_q <= cy_new;
			end
			if (state_q == cdf_pkg::ST_DONE && out_free)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (state_q)
			cdf_pkg::ST_IDLE: begin
				dt_q <= time_step;
				px_q <= point_x;
				py_q <= point_y;
				lim_q <= 1'b0;
				hx_q <= 1'b0;
				hy_q <= 1'b0;
			end
			cdf_pkg::ST_DIFF: begin
				ax_q <= ex;
				ay_q <= ey;
				negx_q <= dx[32];
				negy_q <= dy[32];
			end
			cdf_pkg::ST_MY: ax_q <= step_rnd[48:16];
			cdf_pkg::ST_MS: ay_q <= step_rnd[48:16];
			cdf_pkg::ST_SQX: begin
				ms_q <= ms_rnd[39:16];
				big_q <= (ax_q > ay_q) ? ax_q : ay_q;
			end
			cdf_pkg::ST_SQY: sum_q <= mul_q[49:0];
			cdf_pkg::ST_SQM: sum_q <= sum_q + mul_q[49:0];
			cdf_pkg::ST_CMP: lim_q <= (big_q >= BIG_LIM) || (sum_q > mul_q[49:0]);
			cdf_pkg::ST_SHIFT: begin
				// normalise one bit a cycle until the larger step fits the root
				if (big_q >= LIM) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
					big_q <= big_q >> 1;
				end
			end
			cdf_pkg::ST_RSQ2: rad_q <= mul_q[RW-1:0];
			cdf_pkg::ST_RSQ3: begin
				rad_q <= rad_q + mul_q[RW-1:0];
				res_q <= '0;
				bit_q <= RW'(1) << (RW - 2);
				cnt_q <= cdf_pkg::CNT_W'(H);
			end
			cdf_pkg::ST_SQRT: begin
				if (rad_q >= sq_try) begin
					rad_q <= rad_q - sq_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - cdf_pkg::CNT_W'(1);
			end
			cdf_pkg::ST_LEN: len_q <= (res_q == '0) ? H'(1) : res_q[H-1:0];
			cdf_pkg::ST_DVX0, cdf_pkg::ST_DVY0: begin
				rem_q <= {1'b0, dividend[DW-1:MS_W]};
				quo_q <= dividend[MS_W-1:0];
				cnt_q <= cdf_pkg::CNT_W'(MS_W);
			end
			cdf_pkg::ST_DIVX, cdf_pkg::ST_DIVY: begin
				rem_q <= trial_ge ? (H+1)'(trial - (H+2)'(len_q)) : trial[H:0];
				quo_q <= {quo_q[MS_W-2:0], trial_ge};
				cnt_q <= cnt_q - cdf_pkg::CNT_W'(1);
				if (cnt_q == cdf_pkg::CNT_W'(1)) begin
					if (state_q == cdf_pkg::ST_DIVX)
						ax_q <= MAG_W'({quo_q[MS_W-2:0], trial_ge});
					else
						ay_q <= MAG_W'({quo_q[MS_W-2:0], trial_ge});
				end
			end
			cdf_pkg::ST_ADD: begin
				hx_q <= hx_new;
				hy_q <= hy_new;
			end
			cdf_pkg::ST_DONE: begin
				if (out_free) begin
					cam_x <= camx_q;
					cam_y <= camy_q;
					speed_limited <= lim_q;
					clamped_x <= hx_q;
					clamped_y <= hy_q;
				end
			end
			default: ;
		endcase
	end

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == cdf_pkg::OP_LOAD) |=> state_q == cdf_pkg::ST_DONE)
		else $error("load did not go straight to result");

	a_root_limited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cdf_pkg::ST_SQRT) |-> lim_q)
		else $error("root taken without speed limit");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cdf_pkg::ST_ADD && lim_q) |-> (ax_q <= MAG_W'(ms_q) && ay_q <= MAG_W'(ms_q)))
		else $error("limited step exceeds max step");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == cdf_pkg::ST_DONE)
		else $error("result raised outside completion");

endmodule
`default_nettype wire

FILE: test/camera_deadzone_follow_test.sv
// Self-checking testbench for the camera deadzone follower.
`timescale 1ns / 100ps
module camera_deadzone_follow_test;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               lim;
		logic               hit_x;
		logic               hit_y;
	} cam_result_t;

	class follow_scoreboard;
		logic [30:0]        dz_x, dz_y;
		logic [16:0]        stiff;
		logic [23:0]        max_speed;
		logic signed [31:0] wmin_x, wmax_x, wmin_y, wmax_y;
		longint             cam_x, cam_y;
		cam_result_t        expected_q[$];
		int                 errors;

		function new();
			dz_x = 31'd40960;
			dz_y = 31'd23040;
			stiff = 17'd11796;
			max_speed = '0;
			wmin_x = 1;
			wmax_x = 0;
			wmin_y = 1;
			wmax_y = 0;
			cam_x = 0;
			cam_y = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				cdf_pkg::REG_DZ_X: dz_x = d[30:0];
				cdf_pkg::REG_DZ_Y: dz_y = d[30:0];
				cdf_pkg::REG_STIFF: stiff = d[16:0];
				cdf_pkg::REG_MAX_SPEED: max_speed = d[23:0];
				cdf_pkg::REG_WMIN_X: wmin_x = d;
				cdf_pkg::REG_WMAX_X: wmax_x = d;
				cdf_pkg::REG_WMIN_Y: wmin_y = d;
				cdf_pkg::REG_WMAX_Y: wmax_y = d;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function longint unsigned int_root(longint unsigned rad);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > rad)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (rad >= res + bitv) begin
					rad = rad - (res + bitv);
					res = (res >> 1) + bitv;
				end else
					res = res >> 1;
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		function longint axis_move(longint target, longint cam, longint unsigned half,
				longint unsigned s);
			longint          d;
			longint unsigned m;
			d = target - cam;
			m = d < 0 ? longint'(-d) : longint'(d);
			if (m <= half)
				return 0;
			m = ((m - half) * s + 64'd32768) >> 16;
			return d < 0 ? -longint'(m) : longint'(m);
		endfunction

		function longint clamp_axis(longint v, longint lo, longint hi, output logic hit);
			hit = 1'b0;
			if (lo <= hi) begin
				if (v < lo) begin
					hit = 1'b1;
					return lo;
				end
				if (v > hi) begin
					hit = 1'b1;
					return hi;
				end
			end
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		// Work out the camera after one accepted request and queue it.
		function void note_request(logic op, logic [15:0] dt, logic signed [31:0] px,
				logic signed [31:0] py);
			cam_result_t     r;
			longint unsigned s, step_cap, ax, ay, big, rx, ry, len;
			longint          sx, sy;
			int              sh;
			r.lim = 1'b0;
			r.hit_x = 1'b0;
			r.hit_y = 1'b0;
			if (op == cdf_pkg::OP_LOAD) begin
				cam_x = px;
				cam_y = py;
			end else begin
				s = stiff > cdf_pkg::STIFF_ONE ? 64'(cdf_pkg::STIFF_ONE) : 64'(stiff);
				sx = axis_move(px, cam_x, dz_x, s);
				sy = axis_move(py, cam_y, dz_y, s);
				if (max_speed != 0) begin
					step_cap = (64'(max_speed) * 64'(dt) + 64'd32768) >> 16;
					ax = sx < 0 ? longint'(-sx) : longint'(sx);
					ay = sy < 0 ? longint'(-sy) : longint'(sy);
					big = ax > ay ? ax : ay;
					if (big >= (64'd1 << 24))
						r.lim = 1'b1;
					else
						r.lim = ax * ax + ay * ay > step_cap * step_cap;
					if (r.lim) begin
						sh = 0;
						while ((big >> sh) >= (64'd1 << (cdf_pkg::SQRT_BITS_DEF / 2 - 1)))
							sh++;
						rx = ax >> sh;
						ry = ay >> sh;
						len = int_root(rx * rx + ry * ry);
						if (len == 0)
							len = 1;
						ax = (rx * step_cap + len / 2) / len;
						ay = (ry * step_cap + len / 2) / len;
						sx = sx < 0 ? -longint'(ax) : longint'(ax);
						sy = sy < 0 ? -longint'(ay) : longint'(ay);
					end
				end
				cam_x = clamp_axis(cam_x + sx, wmin_x, wmax_x, r.hit_x);
				cam_y = clamp_axis(cam_y + sy, wmin_y, wmax_y, r.hit_y);
			end
			r.x = cam_x[31:0];
			r.y = cam_y[31:0];
			expected_q.push_back(r);
		endfunction

		function void check_result(cam_result_t got);
			cam_result_t e;
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding: cam_x %0d cam_y %0d", got.x, got.y);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.x !== e.x) begin
				$error("cam_x expected %0d got %0d", e.x, got.x);
				errors++;
			end
			if (got.y !== e.y) begin
				$error("cam_y expected %0d got %0d", e.y, got.y);
				errors++;
			end
			if (got.lim !== e.lim) begin
				$error("speed_limited expected %0b got %0b", e.lim, got.lim);
				errors++;
			end
			if (got.hit_x !== e.hit_x) begin
				$error("clamped_x expected %0b got %0b", e.hit_x, got.hit_x);
				errors++;
			end
			if (got.hit_y !== e.hit_y) begin
				$error("clamped_y expected %0b got %0b", e.hit_y, got.hit_y);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = cdf_pkg::OP_TICK;
	logic [15:0]        time_step = '0;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] cam_x, cam_y;
	logic               speed_limited, clamped_x, clamped_y;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	follow_scoreboard sb = new();
	int send_idle = 27;
	int recv_idle = 59;
	int sent_count = 0;

	camera_deadzone_follow DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .time_step(time_step), .point_x(point_x), .point_y(point_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.cam_x(cam_x), .cam_y(cam_y), .speed_limited(speed_limited),
		.clamped_x(clamped_x), .clamped_y(clamped_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off midway to back the block up.
	always @(posedge clk) begin
		static int hold_left = 0;
		static bit hold_done = 0;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!hold_done && sent_count >= 350) begin
			hold_done = 1;
			hold_left = 400;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		cam_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.x = cam_x;
			got.y = cam_y;
			got.lim = speed_limited;
			got.hit_x = clamped_x;
			got.hit_y = clamped_y;
			sb.check_result(got);
		end
	end

	task automatic send_request(logic op, logic [15:0] dt, logic signed [31:0] px,
			logic signed [31:0] py);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		time_step <= dt;
		point_x <= px;
		point_y <= py;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(op, dt, px, py);
		sent_count++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic load_settings(logic [30:0] dzx, logic [30:0] dzy, logic [16:0] st,
			logic [23:0] ms, logic [31:0] mnx, logic [31:0] mxx, logic [31:0] mny,
			logic [31:0] mxy);
		drain();
		write_reg(cdf_pkg::REG_DZ_X, {1'b0, dzx});
		write_reg(cdf_pkg::REG_DZ_Y, {1'b0, dzy});
		write_reg(cdf_pkg::REG_STIFF, {15'd0, st});
		write_reg(cdf_pkg::REG_MAX_SPEED, {8'd0, ms});
		write_reg(cdf_pkg::REG_WMIN_X, mnx);
		write_reg(cdf_pkg::REG_WMAX_X, mxx);
		write_reg(cdf_pkg::REG_WMIN_Y, mny);
		write_reg(cdf_pkg::REG_WMAX_Y, mxy);
	endtask

	// Mostly targets a spread around the current camera, some loads and wild points.
	task automatic random_request();
		int     r;
		longint offx, offy;
		r = $urandom_range(99);
		if (r < 10)
			send_request(cdf_pkg::OP_LOAD, 16'($urandom), $urandom, $urandom);
		else if (r < 18)
			send_request(cdf_pkg::OP_TICK, 16'($urandom), $urandom, $urandom);
		else begin
			offx = longint'($signed($urandom)) >>> $urandom_range(30);
			offy = longint'($signed($urandom)) >>> $urandom_range(30);
			send_request(cdf_pkg::OP_TICK,
				($urandom_range(3) == 0) ? 16'($urandom_range(64)) : 16'($urandom),
				32'(sb.cam_x + offx), 32'(sb.cam_y + offy));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default settings, extremes of position and time step.
		send_request(cdf_pkg::OP_LOAD, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000);
		send_request(cdf_pkg::OP_TICK, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_request(cdf_pkg::OP_LOAD, 16'h0000, 32'h80000000, 32'h7FFFFFFF);
		send_request(cdf_pkg::OP_TICK, 16'h0000, 32'h7FFFFFFF, 32'h80000000);
		send_request(cdf_pkg::OP_LOAD, 16'h0000, 0, 0);
		// exactly on the deadzone edge, then one past it
		send_request(cdf_pkg::OP_TICK, 16'h1000, 40960, -23040);
		send_request(cdf_pkg::OP_TICK, 16'h1000, 40961, -23041);
		send_request(cdf_pkg::OP_TICK, 16'h1000, -500000, 900000);

		// Speed limit on, stiffness above one, windows enabled.
		load_settings(31'd1000, 31'd0, 17'h1FFFF, 24'd256000, -32'sd256000, 32'sd256000,
			-32'sd128000, 32'sd128000);
		send_request(cdf_pkg::OP_LOAD, 16'h0000, 0, 0);
		send_request(cdf_pkg::OP_TICK, 16'h0000, 500000, -700000);
		send_request(cdf_pkg::OP_TICK, 16'hFFFF, 500000, -700000);
		send_request(cdf_pkg::OP_TICK, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000);
		send_request(cdf_pkg::OP_TICK, 16'h0001, 2000, 3);
		send_request(cdf_pkg::OP_LOAD, 16'h0000, 32'sd9000000, -32'sd9000000);
		send_request(cdf_pkg::OP_TICK, 16'h8000, 32'sd9000000, -32'sd9000000);
		send_request(cdf_pkg::OP_TICK, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: load_settings(31'd0, 31'h7FFFFFFF, 17'h1FFFF, 24'hFFFFFF, 32'h80000000,
					32'h7FFFFFFF, -32'sd50000, 32'sd50000);
				1: load_settings(31'd2560, 31'd1280, 17'd30000, 24'd51200, -32'sd100000,
					32'sd100000, 32'sd5, 32'sd4);
				2: load_settings(31'($urandom_range(8192)), 31'($urandom_range(8192)), 17'd0,
					24'd0, 32'h7FFFFFFF, 32'h80000000, 32'sd0, 32'sd0);
				default: load_settings(31'h7FFFFFFF, 31'd100, cdf_pkg::STIFF_ONE, 24'd1,
					-32'sd1000000, 32'($urandom_range(1000000)), 32'sd0, 32'h7FFFFFFF);
			endcase
			case (p % 3)
				0: begin
					send_idle = 27;
					recv_idle = 59;
				end
				1: begin
					send_idle = 59;
					recv_idle = 27;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int i = 0; i < 150; i++) begin
				if (p == 1 && i == 75) begin
					// pause the sender until the pipeline is empty
					in_valid <= 1'b0;
					@(posedge clk);
					while (sb.pending() != 0)
						@(posedge clk);
				end
				random_request();
			end
		end

		drain();
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
